// ----- rtl/lrupr_pkg.sv -----
`default_nettype none

package lrupr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 8;
    localparam int SLOT_W     = 3;
    localparam int RANK_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCOUNT_W   = 4;
    localparam int FAULT_W    = 16;

    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(4);
    localparam logic [FAULT_W-1:0]  FAULT_MAX    = {FAULT_W{1'b1}};

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [RANK_W-1:0]     rank_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [FAULT_W-1:0]    fault_t;
    typedef logic [FCOUNT_W-1:0]   fcount_t;
    typedef logic [MAX_FRAMES-1:0] frame_mask_t;

endpackage

`default_nettype wire

// ----- rtl/lrupr_req_if.sv -----
`default_nettype none

interface lrupr_req_if
    import lrupr_pkg::*;
();
    logic  valid;
    logic  ready;
    page_t page;
    logic  end_of_string;

    modport source (output valid, output page, output end_of_string, input ready);
    modport sink   (input valid, input page, input end_of_string, output ready);
endinterface

`default_nettype wire

// ----- rtl/lrupr_rsp_if.sv -----
`default_nettype none

interface lrupr_rsp_if
    import lrupr_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   hit;
    slot_t  slot;
    logic   evicted_valid;
    page_t  evicted_page;
    fault_t fault_total;

    modport source (
        output valid, output hit, output slot, output evicted_valid,
        output evicted_page, output fault_total, input ready
    );
    modport sink (
        input valid, input hit, input slot, input evicted_valid,
        input evicted_page, input fault_total, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/lru_page_replacement.sv -----
`default_nettype none

// Fully associative LRU page cache model. Each transfer on req carries one page
// reference and yields exactly one transfer on rsp reporting hit or fault, the
// frame used, any evicted page and the saturating fault total of the current
// string. A new reference is taken on every clock cycle while req is not stalled;
// it is held in the input register, and its result is loaded into the result
// register and offered on rsp from then on. The work in between is the parallel
// compare of all frames together with the recency rank update. Back-pressure on
// rsp stalls req only once both registers are full. A reference marked
// end_of_string clears all frames and the fault total after its own result. The
// frame count is written through cfg_wr_en and cfg_wr_data; the user must write
// it only while no reference is in flight, which the block does not enforce.
// Zero acts as one frame and values above the capacity act as the capacity.
module lru_page_replacement
    import lrupr_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_wr_en,
    input  wire  [FCOUNT_W-1:0] cfg_wr_data,
    lrupr_req_if.sink           req,
    lrupr_rsp_if.source         rsp
);

    fcount_t     frame_count_reg;
    logic        in_valid_reg;
    page_t       in_page_reg;
    logic        in_eos_reg;

    page_t       frame_page_reg  [MAX_FRAMES];
    rank_t       frame_rank_reg  [MAX_FRAMES];
    rank_t       frame_rank_next [MAX_FRAMES];
    frame_mask_t frame_valid_reg;
    frame_mask_t frame_valid_next;
    fault_t      fault_count_reg;
    fault_t      fault_count_next;

    logic        out_valid_reg;
    logic        out_hit_reg;
    slot_t       out_slot_reg;
    logic        out_ev_valid_reg;
    page_t       out_ev_page_reg;
    fault_t      out_fault_reg;

    logic        accept;
    logic        advance;

    frame_mask_t active_mask;
    frame_mask_t match_mask;
    frame_mask_t hit_sel;
    frame_mask_t empty_sel;
    frame_mask_t oldest_sel;
    frame_mask_t sel;
    logic        hit;
    logic        found_empty;
    slot_t       slot;
    rank_t       sel_rank;
    page_t       ev_page;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        logic found_h;
        logic found_e;
        logic oldest_ok;
        found_h     = 1'b0;
        found_e     = 1'b0;
        hit_sel     = '0;
        empty_sel   = '0;
        oldest_sel  = '0;
        active_mask = '0;
        match_mask  = '0;
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            active_mask[j] = (j == 0) || (int'(frame_count_reg) > j);
            match_mask[j]  = active_mask[j] && frame_valid_reg[j]
                             && (frame_page_reg[j] == in_page_reg);
        end
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            if (!found_h && match_mask[j])
            begin
                hit_sel[j] = 1'b1;
                found_h    = 1'b1;
            end
            if (!found_e && active_mask[j] && !frame_valid_reg[j])
            begin
                empty_sel[j] = 1'b1;
                found_e      = 1'b1;
            end
        end
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            oldest_ok = active_mask[j];
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                if (k != j && active_mask[k])
                begin
                    if (k < j)
                    begin
                        oldest_ok = oldest_ok && (frame_rank_reg[j] > frame_rank_reg[k]);
                    end
                    else
                    begin
                        oldest_ok = oldest_ok && (frame_rank_reg[j] >= frame_rank_reg[k]);
                    end
                end
            end
            oldest_sel[j] = oldest_ok;
        end
        hit         = found_h;
        found_empty = found_e;
    end

    always_comb
    begin
        if (hit)
        begin
            sel = hit_sel;
        end
        else if (found_empty)
        begin
            sel = empty_sel;
        end
        else
        begin
            sel = oldest_sel;
        end
        slot     = '0;
        sel_rank = '0;
        ev_page  = '0;
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            if (sel[j])
            begin
                slot     = slot | SLOT_W'(j);
                sel_rank = sel_rank | frame_rank_reg[j];
                ev_page  = ev_page | frame_page_reg[j];
            end
        end
        if (hit || found_empty)
        begin
            ev_page = '0;
        end
    end

    always_comb
    begin
        frame_valid_next = frame_valid_reg | sel;
        fault_count_next = fault_count_reg;
        if (!hit && (fault_count_reg != FAULT_MAX))
        begin
            fault_count_next = fault_count_reg + FAULT_W'(1);
        end
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            frame_rank_next[j] = frame_rank_reg[j];
            if (sel[j])
            begin
                frame_rank_next[j] = '0;
            end
            else if (frame_valid_reg[j] && (found_empty && !hit || frame_rank_reg[j] < sel_rank))
            begin
                frame_rank_next[j] = frame_rank_reg[j] + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FCOUNT_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            frame_valid_reg <= '0;
            fault_count_reg <= '0;
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                frame_rank_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                frame_count_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                if (in_eos_reg)
                begin
                    frame_valid_reg <= '0;
                    fault_count_reg <= '0;
                    for (int j = 0; j < MAX_FRAMES; j++)
                    begin
                        frame_rank_reg[j] <= '0;
                    end
                end
                else
                begin
                    frame_valid_reg <= frame_valid_next;
                    fault_count_reg <= fault_count_next;
                    for (int j = 0; j < MAX_FRAMES; j++)
                    begin
                        frame_rank_reg[j] <= frame_rank_next[j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_page_reg <= req.page;
            in_eos_reg  <= req.end_of_string;
        end
        if (advance)
        begin
            out_hit_reg      <= hit;
            out_slot_reg     <= slot;
            out_ev_valid_reg <= !hit && !found_empty;
            out_ev_page_reg  <= ev_page;
            out_fault_reg    <= fault_count_next;
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                if (sel[j] && !hit)
                begin
                    frame_page_reg[j] <= in_page_reg;
                end
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_total   = out_fault_reg;

`ifndef ASSERT_OFF
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eos_reg) |=> (frame_valid_reg == '0 && fault_count_reg == '0))
        else $error("frames not cleared after end of string");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_eos_reg) |=> (fault_count_reg >= $past(fault_count_reg)))
        else $error("fault total decreased within a string");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_page_reg)))
        else $error("stalled reference lost");

    a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_hit_reg || !out_ev_valid_reg)) |-> (out_ev_page_reg == '0))
        else $error("evicted page reported without eviction");
`endif

endmodule

`default_nettype wire
